// File: rtl/column_gap_splitter_assert.svh
// Assertion macros for the column gap splitter.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef COLUMN_GAP_SPLITTER_ASSERT_SVH
`define COLUMN_GAP_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CGS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cgs_pkg.sv
// Shared types and constants for the column gap splitter.
// No dependencies; imported by the top level, the column store, the split checker and the bench.
`timescale 1ns / 1ps

package cgs_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } cgs_state_t;

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int CFG_W      = 9;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int START_W    = 8;
  localparam int SWIDTH_W   = 10;
  localparam int INDEX_W    = 3;
  localparam int MAX_SIZE   = 256;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd64;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd64;

endpackage

// File: rtl/cgs_col_store.sv
// Column occupancy store: one bit per column, one write and one read port.
// Read data is registered. Uses cgs_pkg for nothing beyond the house import.
`timescale 1ns / 1ps

module cgs_col_store
  import cgs_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/column_gap_splitter.sv
// Column gap splitter top level: pixel intake, column scan and split output.
// Depends on cgs_pkg, cgs_col_store and column_gap_splitter_assert.svh.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------------
//   input   | in_pixel                                | start && !busy
//   result  | out_digit_index .. out_last             | out_valid, one cycle
//   config  | psel penable pwrite paddr pwdata prdata | psel && penable && pwrite
//
// A pixel word is taken when start is high and busy low; busy stays low between
// pixels of a frame. The frame's last pixel starts a sweep over the occupancy store
// of all min(MAX_COLUMNS,256) columns, then DIGITS result words, one word a cycle.
// After reset a clearing pass over all min(MAX_COLUMNS,256) columns holds busy high.
// Results appear in the cycle after they are formed; the receiver cannot stall.
`timescale 1ns / 1ps

module column_gap_splitter
  import cgs_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int DIGITS      = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_pixel,
  output logic                       out_valid,
  output logic [INDEX_W-1:0]         out_digit_index,
  output logic [START_W-1:0]         out_split_start,
  output logic signed [SWIDTH_W-1:0] out_split_width,
  output logic                       out_too_many_runs,
  output logic                       out_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int DEPTH = (MAX_COLUMNS < MAX_SIZE) ? MAX_COLUMNS : MAX_SIZE;
  localparam int COL_W = $clog2(DEPTH);
  localparam int CW    = COL_W + 1;
  localparam int RW    = $clog2(DIGITS + 2);
  localparam int KW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [KW-1:0] KLAST = KW'(DIGITS - 1);
  localparam logic [RW-1:0] RMAX  = RW'(DIGITS + 1);

  cgs_state_t state_r, state_nxt;

  logic [CFG_W-1:0]   width_cfg_r, height_cfg_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [7:0]         row_r, row_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               pv_r, pv_nxt;
  logic [COL_W-1:0]   pa_r, pa_nxt;
  logic               prev_r, prev_nxt;
  logic [COL_W-1:0]   gap_start_r, gap_start_nxt;
  logic [CW-1:0]      gap_len_r, gap_len_nxt;
  logic [RW-1:0]      runs_r, runs_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [START_W-1:0] split_r   [DIGITS];
  logic [START_W-1:0] split_nxt [DIGITS];

  logic                       out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]         out_index_r, out_index_nxt;
  logic [START_W-1:0]         out_start_r, out_start_nxt;
  logic [SWIDTH_W-1:0]        out_width_r, out_width_nxt;
  logic                       out_flag_r, out_flag_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [CFG_W-1:0] w_eff, h_eff;
  logic             accept, frame_end, col_end, row_end;
  logic             ink;
  logic [8:0]       split_sum;
  logic [CFG_W-1:0] next_start;
  logic             cfg_wr;

  logic             ram_we, ram_wdata, ram_rdata;
  logic [COL_W-1:0] ram_waddr;

  // Effective frame size: zero acts as one, oversize saturates.
  always_comb begin
    if (width_cfg_r == '0) begin
      w_eff = CFG_W'(1);
    end else if (width_cfg_r > CFG_W'(DEPTH)) begin
      w_eff = CFG_W'(DEPTH);
    end else begin
      w_eff = width_cfg_r;
    end
    if (height_cfg_r == '0) begin
      h_eff = CFG_W'(1);
    end else if (height_cfg_r > CFG_W'(MAX_SIZE)) begin
      h_eff = CFG_W'(MAX_SIZE);
    end else begin
      h_eff = height_cfg_r;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign col_end   = (10'(col_r) + 10'd1) >= 10'(w_eff);
  assign row_end   = (10'(row_r) + 10'd1) >= 10'(h_eff);
  assign frame_end = col_end && row_end;
  assign ink       = ram_rdata && (10'(pa_r) < 10'(w_eff));
  assign split_sum = 9'(gap_start_r) + 9'(gap_len_r >> 1);
  assign next_start = (k_r == KLAST) ? w_eff : CFG_W'(split_r[1 % DIGITS]);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WIDTH_RST;
      height_cfg_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_cfg_r <= pwdata[CFG_W-1:0];
      end else begin
        height_cfg_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_WIDTH) begin
      prdata = DATA_W'(width_cfg_r);
    end else begin
      prdata = DATA_W'(height_cfg_r);
    end
  end

  // Store write port: clearing pass, pixel OR, and clear-behind during the scan.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col_r;
    ram_wdata = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[COL_W-1:0];
      end
      ST_IDLE: begin
        ram_we    = accept && in_pixel;
        ram_waddr = col_r;
        ram_wdata = 1'b1;
      end
      ST_SCAN: begin
        ram_we    = pv_r;
        ram_waddr = pa_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cgs_col_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (COL_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[COL_W-1:0]),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == CW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && frame_end) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == CW'(DEPTH) && !pv_r) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (k_r == KLAST) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Datapath and output words.
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pa_nxt        = pa_r;
    prev_nxt      = prev_r;
    gap_start_nxt = gap_start_r;
    gap_len_nxt   = gap_len_r;
    runs_nxt      = runs_r;
    k_nxt         = k_r;
    split_nxt     = split_r;
    out_valid_nxt = 1'b0;
    out_index_nxt = out_index_r;
    out_start_nxt = out_start_r;
    out_width_nxt = out_width_r;
    out_flag_nxt  = out_flag_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          if (col_end) begin
            col_nxt = '0;
            row_nxt = row_end ? 8'd0 : row_r + 8'd1;
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
          if (frame_end) begin
            cnt_nxt       = '0;
            prev_nxt      = 1'b0;
            gap_start_nxt = '0;
            gap_len_nxt   = '0;
            runs_nxt      = '0;
            k_nxt         = '0;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_r < CW'(DEPTH)) begin
          pv_nxt  = 1'b1;
          pa_nxt  = cnt_r[COL_W-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
        // Columns beyond the frame width are only cleared.
        if (pv_r && (10'(pa_r) < 10'(w_eff))) begin
          if (ink) begin
            if (pa_r == '0 || !prev_r) begin
              for (int i = 0; i < DIGITS; i++) begin
                if (runs_r == RW'(i)) split_nxt[i] = split_sum[START_W-1:0];
              end
              if (runs_r != RMAX) runs_nxt = runs_r + RW'(1);
            end
          end else begin
            if (pa_r == '0 || prev_r) begin
              gap_start_nxt = pa_r;
              gap_len_nxt   = CW'(1);
            end else begin
              gap_len_nxt = gap_len_r + CW'(1);
            end
          end
          prev_nxt = ink;
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_index_nxt = INDEX_W'(k_r);
        out_start_nxt = split_r[0];
        out_width_nxt = SWIDTH_W'(next_start) - SWIDTH_W'(split_r[0]);
        out_flag_nxt  = (runs_r > RW'(DIGITS));
        out_last_nxt  = (k_r == KLAST);
        k_nxt         = k_r + KW'(1);
        // Advance the split list; zeros shift in, leaving it clear for the next frame.
        for (int i = 0; i < DIGITS; i++) begin
          split_nxt[i] = (i < DIGITS - 1) ? split_r[(i + 1) % DIGITS] : '0;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      prev_r      <= 1'b0;
      gap_start_r <= '0;
      gap_len_r   <= '0;
      runs_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        split_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      prev_r      <= prev_nxt;
      gap_start_r <= gap_start_nxt;
      gap_len_r   <= gap_len_nxt;
      runs_r      <= runs_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      split_r     <= split_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r        <= pa_nxt;
    out_index_r <= out_index_nxt;
    out_start_r <= out_start_nxt;
    out_width_r <= out_width_nxt;
    out_flag_r  <= out_flag_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_digit_index   = out_index_r;
  assign out_split_start   = out_start_r;
  assign out_split_width   = out_width_r;
  assign out_too_many_runs = out_flag_r;
  assign out_last          = out_last_r;

`include "column_gap_splitter_assert.svh"

  `CGS_ASSERT_IMPL(a_out_from_emit, out_valid, $past(state_r == ST_EMIT), "word without emit")
  `CGS_ASSERT_NEXT(a_words_back_to_back, out_valid && !out_last, out_valid, "gap in results")
  `CGS_ASSERT_NEXT(a_last_ends_burst, out_valid && out_last, !out_valid, "word after last")
  `CGS_ASSERT_IMPL(a_scan_pipe, pv_r, state_r == ST_SCAN, "scan read outside scan")

endmodule

// File: bench/cgs_split_checker.sv
// Split checker for the column gap splitter: watches the pixel, result and APB ports,
// keeps its own column occupancy and predicts every split word of a frame.
// Depends on cgs_pkg.
`timescale 1ns / 1ps

module cgs_split_checker
  import cgs_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int DIGITS      = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_pixel,
  input  logic                out_valid,
  input  logic [INDEX_W-1:0]  out_digit_index,
  input  logic [START_W-1:0]  out_split_start,
  input  logic [SWIDTH_W-1:0] out_split_width,
  input  logic                out_too_many_runs,
  input  logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic [DATA_W-1:0]   prdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  splits_due
);

  localparam int WIDTH_LIM = (MAX_COLUMNS < MAX_SIZE) ? MAX_COLUMNS : MAX_SIZE;

  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic [START_W-1:0]  col;
    logic [SWIDTH_W-1:0] width;
    logic                many;
    logic                last;
  } split_t;

  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic               ink_col [MAX_COLUMNS];
  logic [START_W-1:0] split_cols [DIGITS];
  int                 row_cnt;
  int                 col_cnt;
  split_t             split_q [$];

  initial fail_count = 0;

  function automatic int clamp_size(logic [CFG_W-1:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  task automatic clear_frame();
    foreach (ink_col[i]) ink_col[i] = 1'b0;
    foreach (split_cols[i]) split_cols[i] = '0;
    row_cnt = 0;
    col_cnt = 0;
  endtask

  task automatic note_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Sweep the columns left to right, then queue one split word per slot.
  task automatic close_frame(int w);
    int     runs;
    int     gap_from;
    int     gap_len;
    int     nxt;
    logic   prev;
    split_t s;
    runs = 0;
    gap_from = 0;
    gap_len = 0;
    prev = 1'b0;
    for (int x = 0; x < w; x++) begin
      if (ink_col[x]) begin
        if (x == 0 || !prev) begin
          if (runs < DIGITS) split_cols[runs] = START_W'(gap_from + gap_len / 2);
          if (runs < 255) runs++;
        end
      end else begin
        if (x == 0 || prev) begin
          gap_from = x;
          gap_len = 0;
        end
        gap_len++;
      end
      prev = ink_col[x];
    end
    for (int k = 0; k < DIGITS; k++) begin
      nxt = (k + 1 < DIGITS) ? int'(split_cols[k+1]) : w;
      s.index = INDEX_W'(k);
      s.col   = split_cols[k];
      s.width = SWIDTH_W'(nxt - int'(split_cols[k]));
      s.many  = runs > DIGITS;
      s.last  = (k == DIGITS - 1);
      split_q.push_back(s);
    end
  endtask

  task automatic absorb_pixel(logic v);
    int w;
    int h;
    w = clamp_size(width_reg, WIDTH_LIM);
    h = clamp_size(height_reg, MAX_SIZE);
    if (col_cnt < MAX_COLUMNS && v) ink_col[col_cnt] = 1'b1;
    if (col_cnt + 1 < w) begin
      col_cnt++;
      return;
    end
    col_cnt = 0;
    if (row_cnt + 1 < h) begin
      row_cnt++;
      return;
    end
    close_frame(w);
    clear_frame();
  endtask

  always @(posedge clk) begin
    split_t want;
    if (!rst_n) begin
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      clear_frame();
      split_q.delete();
    end else begin
      if (out_valid) begin
        if (split_q.size() == 0) begin
          $error("split word with none pending: digit_index %0d", out_digit_index);
          fail_count++;
        end else begin
          want = split_q.pop_front();
          note_field("digit_index", want.index, out_digit_index);
          note_field("split_start", want.col, out_split_start);
          note_field("split_width", want.width, out_split_width);
          note_field("too_many_runs", want.many, out_too_many_runs);
          note_field("last", want.last, out_last);
        end
      end
      // A pixel taken on the same edge as a write still sees the old sizes.
      if (start && !busy) absorb_pixel(in_pixel);
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_WIDTH:  width_reg = pwdata[CFG_W-1:0];
            REG_HEIGHT: height_reg = pwdata[CFG_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[ADDR_W-1:2])
            REG_WIDTH:  note_field("prdata", width_reg, prdata);
            REG_HEIGHT: note_field("prdata", height_reg, prdata);
            default: ;
          endcase
        end
      end
    end
    splits_due = split_q.size();
  end

endmodule

// File: bench/tb.sv
// Top of the column gap splitter bench: clock, reset, pixel and APB stimulus, verdict.
// Depends on cgs_pkg, column_gap_splitter and cgs_split_checker.
`timescale 1ns / 1ps

module tb;
  import cgs_pkg::*;

  localparam int MAX_COLUMNS = 256;
  localparam int DIGITS      = 4;
  // column sweep plus result words plus margin
  localparam int SETTLE      = 300;
  localparam int PIXELS      = 220;

  logic                clk;
  logic                rst_n    = 1'b0;
  logic                start    = 1'b0;
  logic                in_pixel = 1'b0;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ADDR_W-1:0]   paddr    = '0;
  logic [DATA_W-1:0]   pwdata   = '0;
  logic                busy;
  logic                out_valid;
  logic [INDEX_W-1:0]  out_digit_index;
  logic [START_W-1:0]  out_split_start;
  logic [SWIDTH_W-1:0] out_split_width;
  logic                out_too_many_runs;
  logic                out_last;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int fail_count;
  int splits_due;
  int cur_w;
  int cur_h;
  int burst_left  = 0;
  int pixels_sent = 0;

  column_gap_splitter #(.MAX_COLUMNS(MAX_COLUMNS), .DIGITS(DIGITS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_digit_index(out_digit_index),
    .out_split_start(out_split_start), .out_split_width(out_split_width),
    .out_too_many_runs(out_too_many_runs), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cgs_split_checker #(.MAX_COLUMNS(MAX_COLUMNS), .DIGITS(DIGITS)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_digit_index(out_digit_index),
    .out_split_start(out_split_start), .out_split_width(out_split_width),
    .out_too_many_runs(out_too_many_runs), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .splits_due(splits_due)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #20_000_000;
    $display("** column_gap_splitter: FAILED **");
    $finish;
  end

  function automatic int size_of(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIZE) return MAX_SIZE;
    return int'(v);
  endfunction

  // Send one pixel word; bursts of random length with random gaps between them.
  task automatic send_pixel(logic v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    start <= 1'b1;
    in_pixel <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    burst_left--;
    pixels_sent++;
  endtask

  // Hold the pixel source until every pending split word has come out.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (splits_due != 0) @(negedge clk);
  endtask

  task automatic apb_access(logic wr, logic idx, logic [CFG_W-1:0] value);
    logic [DATA_W-1:0] word;
    drain();
    if (wr) repeat (SETTLE) @(negedge clk);
    word = $urandom;
    word[CFG_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_size(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
    apb_access(1'b1, REG_WIDTH, wv);
    apb_access(1'b1, REG_HEIGHT, hv);
    if ($urandom_range(0, 2) == 0) begin
      apb_access(1'b0, REG_WIDTH, '0);
      apb_access(1'b0, REG_HEIGHT, '0);
    end
    cur_w = size_of(wv);
    cur_h = size_of(hv);
  endtask

  // One frame: columns laid out as alternating ink and gap runs, each ink column
  // hit on one chosen row at least; noise frames are plain random pixels.
  task automatic send_frame(bit noise);
    logic ink [MAX_SIZE];
    int   hit_row [MAX_SIZE];
    int   c;
    int   run_len;
    int   run_max;
    logic cur;
    run_max = (cur_w < 8) ? cur_w : cur_w / 2;
    c = 0;
    cur = 1'($urandom_range(0, 1));
    while (c < cur_w) begin
      run_len = $urandom_range(1, run_max);
      while (run_len > 0 && c < cur_w) begin
        ink[c] = cur;
        hit_row[c] = $urandom_range(0, cur_h - 1);
        c++;
        run_len--;
      end
      cur = !cur;
    end
    for (int r = 0; r < cur_h; r++) begin
      for (int x = 0; x < cur_w; x++) begin
        if (noise) send_pixel(1'($urandom_range(0, 1)));
        else send_pixel(ink[x] && (r == hit_row[x] || $urandom_range(0, 2) == 0));
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    int               pick;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset values of both registers
    apb_access(1'b0, REG_WIDTH, '0);
    apb_access(1'b0, REG_HEIGHT, '0);

    // oversize values read back unclamped
    apb_access(1'b1, REG_WIDTH, 9'd511);
    apb_access(1'b1, REG_HEIGHT, 9'd300);
    apb_access(1'b0, REG_WIDTH, '0);
    apb_access(1'b0, REG_HEIGHT, '0);

    // zero sizes act as one: single-pixel frames with ink at column 0 and without
    set_size(9'd0, 9'd0);
    send_pixel(1'b1);
    send_pixel(1'b0);

    // five ink runs in nine columns: extra runs dropped and flagged
    set_size(9'd9, 9'd1);
    for (int x = 0; x < 9; x++) send_pixel(x % 2 == 0);

    // one run away from column 0, ink on the first row only
    set_size(9'd4, 9'd2);
    for (int x = 0; x < 8; x++) send_pixel(x == 1 || x == 2);

    // shrink width, then height, in the middle of a frame
    send_pixel(1'b1);
    send_pixel(1'b1);
    apb_access(1'b1, REG_WIDTH, 9'd2);
    send_pixel(1'b0);
    apb_access(1'b1, REG_HEIGHT, 9'd1);
    while (splits_due == 0) send_pixel(1'($urandom_range(0, 1)));
    cur_w = 2;
    cur_h = 1;

    while (pixels_sent < PIXELS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) wv = 9'd0;
      else wv = 9'($urandom_range(1, 24));
      if ($urandom_range(0, 7) == 0) hv = 9'd0;
      else hv = 9'($urandom_range(1, 4));
      set_size(wv, hv);
      repeat ($urandom_range(1, 3)) begin
        if (pixels_sent < PIXELS) send_frame($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("** column_gap_splitter: PASSED **");
    end else begin
      $display("** column_gap_splitter: FAILED **");
    end
    $finish;
  end

endmodule
